### rtl/graph_depth_first_traversal_top_assert.svh
// assertion macros shared by the checker files
// no dependencies; expects clock and reset in the scope of use
`ifndef GRAPH_DEPTH_FIRST_TRAVERSAL_TOP_ASSERT_SVH
`define GRAPH_DEPTH_FIRST_TRAVERSAL_TOP_ASSERT_SVH

// consequent checked in the same cycle
`define GDFT_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the next cycle
`define GDFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/gdft_pkg.sv
// shared constants, codes and types of the depth-first traversal block
// no dependencies
`default_nettype none

package gdft_pkg;

   localparam int MAX_VERTEX_COUNT = 64;
   localparam int MAX_EDGE_COUNT   = 256;

   // fixed beat field widths
   localparam int KIND_W   = 2;
   localparam int VERTEX_W = 6;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 7;

   // internal widths
   localparam int VIDX_W  = $clog2(MAX_VERTEX_COUNT);
   localparam int EIDX_W  = $clog2(MAX_EDGE_COUNT);
   localparam int LINK_W  = EIDX_W + 1;   // msb set means null link
   localparam int ECNT_W  = EIDX_W + 1;
   localparam int DEPTH_W = VIDX_W + 1;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);
   localparam logic [CFG_W-1:0] LIMIT_MAX = CFG_W'(MAX_VERTEX_COUNT);

   localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ADD      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TRAVERSE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_VERTEX      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_START   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EDGE_REJECT = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_HEAD,
      ST_STEP,
      ST_EDGE,
      ST_POP,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [VIDX_W-1:0] target;
      logic [LINK_W-1:0] link;
   } edge_type;

   typedef struct packed {
      logic [VIDX_W-1:0] vertex;
      logic [LINK_W-1:0] link;
   } frame_type;

endpackage

`default_nettype wire

### rtl/graph_depth_first_traversal_top.sv
// depth-first traversal engine over per-vertex linked edge lists
// depends on gdft_pkg
`default_nettype none

// Directed-graph store with depth-first walk. Three request kinds: clear empties
// every edge list and every visited mark (no response); add edge prepends the
// edge to its source's list (head read, then head and edge write; no response
// unless rejected); traverse emits the start vertex and every reachable
// unvisited vertex in recursive depth-first order, the final beat flagged with
// rsp_last. Rejected edges (vertex at or above the limit, or edge store full)
// and bad start vertices give one status beat. Visited marks stay set until the
// next clear. The limit is csr num_vertices, saturated at the vertex count;
// write it only while the block is idle. The walk is paced by the registered
// memory reads: each edge looked at takes an edge read and a visited check,
// each vertex emitted a head read, an end-of-list check, then a stack pop or
// the final flush, and the walk waits while the consumer stalls a beat that is
// ready. No clearing pass is needed after reset: list heads and visited marks
// carry flip-flop valid bits. One request is in flight at a time; req_stall is
// high while a request is at work, and the response register lets the walk
// run ahead by one beat while the consumer stalls.
module graph_depth_first_traversal_top
   import gdft_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   // request channel
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [KIND_W-1:0]     req_kind,
   input  wire  [VERTEX_W-1:0]   req_src,
   input  wire  [VERTEX_W-1:0]   req_dest,
   // response channel
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic [VERTEX_W-1:0]   rsp_visited_vertex,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_last,
   // configuration
   input  wire                   csr_wr_en,
   input  wire  [CFG_W-1:0]      csr_wr_data
);

   // sequencer state
   state_type state_ff, state_in;

   // configuration
   logic [CFG_W-1:0] num_vertices_ff;

   // visited marks and list head valid bits live in flops
   logic [MAX_VERTEX_COUNT-1:0] visited_ff, visited_in;
   logic [MAX_VERTEX_COUNT-1:0] head_valid_ff, head_valid_in;
   logic [ECNT_W-1:0]           edge_count_ff, edge_count_in;

   // memories
   logic [EIDX_W-1:0] head_mem  [MAX_VERTEX_COUNT];
   edge_type          edge_mem  [MAX_EDGE_COUNT];
   frame_type         stack_mem [MAX_VERTEX_COUNT];

   // registered read data
   logic [LINK_W-1:0] head_q_ff;   // null when the head was not written since reset or the last clear
   edge_type          edge_q_ff;
   frame_type         stack_q_ff;

   // top of stack kept in flops, the rest in stack_mem
   logic [VIDX_W-1:0]  top_vertex_ff, top_vertex_in;
   logic [LINK_W-1:0]  top_link_ff, top_link_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;

   // latched add-edge operands
   logic [VIDX_W-1:0] add_src_ff, add_src_in;
   logic [VIDX_W-1:0] add_dest_ff, add_dest_in;

   // pending beat: held back until we know whether it is the last one
   logic                pend_valid_ff, pend_valid_in;
   logic [VIDX_W-1:0]   pend_vertex_ff, pend_vertex_in;
   logic [STATUS_W-1:0] pend_status_ff, pend_status_in;

   // response register
   logic                out_valid_ff, out_valid_in;
   logic [VERTEX_W-1:0] out_vertex_ff, out_vertex_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic                out_last_ff, out_last_in;

   // memory port controls
   logic              head_rd_en;
   logic [VIDX_W-1:0] head_rd_addr;
   logic              head_wr_en;
   logic              edge_rd_en;
   logic              edge_wr_en;
   logic              stack_rd_en;
   logic              stack_wr_en;
   logic [VIDX_W-1:0] stack_rd_addr;

   // decode helpers
   logic               accept;
   logic [CFG_W-1:0]   limit;
   logic               src_ok, dest_ok, edge_full;
   logic [VIDX_W-1:0]  src_v, dest_v;
   logic               top_null;
   logic               edge_new;
   logic               out_free;
   logic [DEPTH_W-1:0] depth_dec;

   assign accept    = req_valid && !req_stall;
   assign limit     = (num_vertices_ff > LIMIT_MAX) ? LIMIT_MAX : num_vertices_ff;
   assign src_ok    = CFG_W'(req_src) < limit;
   assign dest_ok   = CFG_W'(req_dest) < limit;
   assign src_v     = req_src[VIDX_W-1:0];
   assign dest_v    = req_dest[VIDX_W-1:0];
   assign edge_full = edge_count_ff == ECNT_W'(MAX_EDGE_COUNT);
   assign top_null  = top_link_ff[LINK_W-1];
   assign edge_new  = !visited_ff[edge_q_ff.target];
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign depth_dec = depth_ff - DEPTH_W'(1);

   assign stack_rd_addr = depth_dec[VIDX_W-1:0];

   // ports
   assign req_stall          = state_ff != ST_IDLE;
   assign rsp_valid          = out_valid_ff;
   assign rsp_visited_vertex = out_vertex_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_last           = out_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_ADD:      state_in = (src_ok && dest_ok && !edge_full) ? ST_ADD
                                                                              : ST_FLUSH;
                  KIND_TRAVERSE: state_in = src_ok ? ST_HEAD : ST_FLUSH;
                  default:       state_in = ST_IDLE;   // clear, unused kind
               endcase
            end
         end
         ST_ADD:  state_in = ST_IDLE;
         ST_HEAD: state_in = ST_STEP;
         ST_STEP: begin
            if (!top_null) begin
               state_in = ST_EDGE;
            end else if (depth_ff != '0) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_FLUSH;
            end
         end
         ST_EDGE: begin
            if (!edge_new) begin
               state_in = ST_STEP;
            end else if (out_free) begin
               state_in = ST_HEAD;
            end
         end
         ST_POP:   state_in = ST_STEP;
         ST_FLUSH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      visited_in     = visited_ff;
      head_valid_in  = head_valid_ff;
      edge_count_in  = edge_count_ff;
      top_vertex_in  = top_vertex_ff;
      top_link_in    = top_link_ff;
      depth_in       = depth_ff;
      add_src_in     = add_src_ff;
      add_dest_in    = add_dest_ff;
      pend_valid_in  = pend_valid_ff;
      pend_vertex_in = pend_vertex_ff;
      pend_status_in = pend_status_ff;
      out_valid_in   = out_valid_ff && rsp_stall;
      out_vertex_in  = out_vertex_ff;
      out_status_in  = out_status_ff;
      out_last_in    = out_last_ff;
      head_rd_en     = 1'b0;
      head_rd_addr   = src_v;
      head_wr_en     = 1'b0;
      edge_rd_en     = 1'b0;
      edge_wr_en     = 1'b0;
      stack_rd_en    = 1'b0;
      stack_wr_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_kind)
                  KIND_CLEAR: begin
                     visited_in    = '0;
                     head_valid_in = '0;
                     edge_count_in = '0;
                     depth_in      = '0;
                  end
                  KIND_ADD: begin
                     add_src_in  = src_v;
                     add_dest_in = dest_v;
                     if (src_ok && dest_ok && !edge_full) begin
                        head_rd_en = 1'b1;   // fetch current head for the new link
                     end else begin
                        pend_valid_in  = 1'b1;
                        pend_vertex_in = '0;
                        pend_status_in = STATUS_EDGE_REJECT;
                     end
                  end
                  KIND_TRAVERSE: begin
                     pend_valid_in = 1'b1;
                     if (src_ok) begin
                        // start vertex is emitted even if already visited
                        visited_in[src_v] = 1'b1;
                        pend_vertex_in    = src_v;
                        pend_status_in    = STATUS_VERTEX;
                        top_vertex_in     = src_v;
                        depth_in          = '0;
                        head_rd_en        = 1'b1;
                     end else begin
                        pend_vertex_in = '0;
                        pend_status_in = STATUS_BAD_START;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ADD: begin
            head_wr_en                = 1'b1;
            edge_wr_en                = 1'b1;
            head_valid_in[add_src_ff] = 1'b1;
            edge_count_in             = edge_count_ff + ECNT_W'(1);
         end
         ST_HEAD: begin
            top_link_in = head_q_ff;
         end
         ST_STEP: begin
            if (!top_null) begin
               edge_rd_en = 1'b1;
            end else if (depth_ff != '0) begin
               stack_rd_en = 1'b1;
               depth_in    = depth_dec;
            end
         end
         ST_EDGE: begin
            top_link_in = edge_q_ff.link;
            if (edge_new && out_free) begin
               // push the current frame, descend into the new vertex
               stack_wr_en                  = 1'b1;
               depth_in                     = depth_ff + DEPTH_W'(1);
               visited_in[edge_q_ff.target] = 1'b1;
               out_valid_in                 = 1'b1;
               out_vertex_in                = VERTEX_W'(pend_vertex_ff);
               out_status_in                = pend_status_ff;
               out_last_in                  = 1'b0;
               pend_vertex_in               = edge_q_ff.target;
               pend_status_in               = STATUS_VERTEX;
               top_vertex_in                = edge_q_ff.target;
               head_rd_en                   = 1'b1;
               head_rd_addr                 = edge_q_ff.target;
            end
         end
         ST_POP: begin
            top_vertex_in = stack_q_ff.vertex;
            top_link_in   = stack_q_ff.link;
         end
         ST_FLUSH: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_vertex_in = VERTEX_W'(pend_vertex_ff);
               out_status_in = pend_status_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         num_vertices_ff <= CFG_RESET;
         visited_ff      <= '0;
         head_valid_ff   <= '0;
         edge_count_ff   <= '0;
         depth_ff        <= '0;
         pend_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         visited_ff    <= visited_in;
         head_valid_ff <= head_valid_in;
         edge_count_ff <= edge_count_in;
         depth_ff      <= depth_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         if (csr_wr_en) begin
            num_vertices_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      top_vertex_ff  <= top_vertex_in;
      top_link_ff    <= top_link_in;
      add_src_ff     <= add_src_in;
      add_dest_ff    <= add_dest_in;
      pend_vertex_ff <= pend_vertex_in;
      pend_status_ff <= pend_status_in;
      out_vertex_ff  <= out_vertex_in;
      out_status_ff  <= out_status_in;
      out_last_ff    <= out_last_in;
   end

   // list head memory, valid bit folded into the null flag on read
   always_ff @(posedge clock) begin
      if (head_wr_en) begin
         head_mem[add_src_ff] <= edge_count_ff[EIDX_W-1:0];
      end
      if (head_rd_en) begin
         head_q_ff <= {!head_valid_ff[head_rd_addr], head_mem[head_rd_addr]};
      end
   end

   // edge memory: target and next link
   always_ff @(posedge clock) begin
      if (edge_wr_en) begin
         edge_mem[edge_count_ff[EIDX_W-1:0]] <= '{target: add_dest_ff, link: head_q_ff};
      end
      if (edge_rd_en) begin
         edge_q_ff <= edge_mem[top_link_ff[EIDX_W-1:0]];
      end
   end

   // walk stack memory, frames below the top
   always_ff @(posedge clock) begin
      if (stack_wr_en) begin
         stack_mem[depth_ff[VIDX_W-1:0]] <= '{vertex: top_vertex_ff, link: edge_q_ff.link};
      end
      if (stack_rd_en) begin
         stack_q_ff <= stack_mem[stack_rd_addr];
      end
   end

endmodule

`default_nettype wire

### rtl/gdft_checker.sv
// port-level checker for the depth-first traversal block, with its bind
// depends on gdft_pkg and graph_depth_first_traversal_top_assert.svh
`default_nettype none

`include "graph_depth_first_traversal_top_assert.svh"

module gdft_checker
   import gdft_pkg::*;
(
   input wire                 clock,
   input wire                 reset,
   input wire                 req_valid,
   input wire                 req_stall,
   input wire [KIND_W-1:0]    req_kind,
   input wire                 rsp_valid,
   input wire                 rsp_stall,
   input wire [VERTEX_W-1:0]  rsp_visited_vertex,
   input wire [STATUS_W-1:0]  rsp_status,
   input wire                 rsp_last
);

   // a stalled response beat holds
   `GDFT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_visited_vertex) && $stable(rsp_status) && $stable(rsp_last), "response beat changed under stall")

   // status beats are single, final and carry vertex zero
   `GDFT_ASSERT_SAME(a_status_beat, rsp_valid && rsp_status != STATUS_VERTEX, rsp_last && rsp_visited_vertex == '0, "malformed status beat")

   // clear and unused kinds leave the block idle in the next cycle
   `GDFT_ASSERT_NEXT(a_quick_kind, req_valid && !req_stall && req_kind != KIND_ADD && req_kind != KIND_TRAVERSE, !req_stall, "clear left the block busy")

   // traverse always owes at least one beat, so the block is busy afterwards
   `GDFT_ASSERT_NEXT(a_walk_busy, req_valid && !req_stall && req_kind == KIND_TRAVERSE, req_stall, "traverse did not occupy the block")

endmodule

bind graph_depth_first_traversal_top gdft_checker u_gdft_checker (.*);

`default_nettype wire

### tb/graph_depth_first_traversal_top_tb.sv
// self-checking bench for the depth-first traversal block: directed graphs, a full edge store
// and random graphs under several vertex limits; depends on gdft_pkg and graph_depth_first_traversal_top
module graph_depth_first_traversal_top_tb;
   import gdft_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int NO_LINK       = -1;

   // the package names three request kinds; the fourth code is ignored by the block
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [VERTEX_W-1:0] vertex;
      logic [STATUS_W-1:0] status;
      logic                last;
   } visit_beat_t;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [KIND_W-1:0]   req_kind    = KIND_CLEAR;
   logic [VERTEX_W-1:0] req_src     = '0;
   logic [VERTEX_W-1:0] req_dest    = '0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic [VERTEX_W-1:0] rsp_visited_vertex;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_last;
   logic                csr_wr_en   = 1'b0;
   logic [CFG_W-1:0]    csr_wr_data = '0;

   graph_depth_first_traversal_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_src            (req_src),
      .req_dest           (req_dest),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_visited_vertex (rsp_visited_vertex),
      .rsp_status         (rsp_status),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // graph shadow: visited marks, list heads, edge store and the vertex limit register
   logic [CFG_W-1:0]    vertex_cap = CFG_RESET;
   bit                  seen [MAX_VERTEX_COUNT];
   int                  list_head [MAX_VERTEX_COUNT];
   logic [VERTEX_W-1:0] arc_dest [MAX_EDGE_COUNT];
   int                  arc_next [MAX_EDGE_COUNT];
   int                  arc_total;

   // beats still owed by the block, oldest first
   visit_beat_t         expected_visits [$];
   visit_beat_t         oldest_visit;

   int unsigned         mismatch_count = 0;
   int unsigned         cycle_count    = 0;
   int unsigned         stall_left     = 0;
   // when set, neither side idles: back-to-back requests and no consumer stalls
   bit                  steady         = 1'b0;

   function automatic int unsigned draw_wait();
      return steady ? 0 : $urandom_range(4);
   endfunction

   function automatic void forget_graph();
      for (int v = 0; v < MAX_VERTEX_COUNT; v++) begin
         seen[v]      = 1'b0;
         list_head[v] = NO_LINK;
      end
      arc_total = 0;
   endfunction

   // register values above the vertex count saturate
   function automatic int vertex_limit();
      return (vertex_cap > LIMIT_MAX) ? MAX_VERTEX_COUNT : int'(vertex_cap);
   endfunction

   function automatic void owe_status(logic [STATUS_W-1:0] code);
      visit_beat_t beat;
      beat.vertex = '0;
      beat.status = code;
      beat.last   = 1'b1;
      expected_visits.push_back(beat);
   endfunction

   // depth-first order with an explicit stack of next-edge links; the start is
   // emitted even when already visited, later-added edges are walked first
   function automatic void walk_from(logic [VERTEX_W-1:0] start);
      logic [VERTEX_W-1:0] order [$];
      int                  frame_link [MAX_VERTEX_COUNT];
      int                  depth;
      int                  arc;
      logic [VERTEX_W-1:0] hop;
      visit_beat_t         beat;
      seen[start] = 1'b1;
      order.push_back(start);
      frame_link[0] = list_head[start];
      depth = 1;
      while (depth > 0) begin
         arc = frame_link[depth-1];
         if (arc == NO_LINK) begin
            depth--;
         end else begin
            hop = arc_dest[arc];
            frame_link[depth-1] = arc_next[arc];
            if (!seen[hop]) begin
               seen[hop] = 1'b1;
               order.push_back(hop);
               frame_link[depth] = list_head[hop];
               depth++;
            end
         end
      end
      foreach (order[i]) begin
         beat.vertex = order[i];
         beat.status = STATUS_VERTEX;
         beat.last   = (i == order.size() - 1);
         expected_visits.push_back(beat);
      end
   endfunction

   function automatic void predict_visits(logic [KIND_W-1:0] kind, logic [VERTEX_W-1:0] src,
                                          logic [VERTEX_W-1:0] dest);
      int lim;
      lim = vertex_limit();
      case (kind)
         KIND_CLEAR: begin
            forget_graph();
         end
         KIND_ADD: begin
            if (src >= lim || dest >= lim || arc_total >= MAX_EDGE_COUNT) begin
               owe_status(STATUS_EDGE_REJECT);
            end else begin
               // prepend to the source's list
               arc_dest[arc_total] = dest;
               arc_next[arc_total] = list_head[src];
               list_head[src]      = arc_total;
               arc_total++;
            end
         end
         KIND_TRAVERSE: begin
            if (src >= lim) begin
               owe_status(STATUS_BAD_START);
            end else begin
               walk_from(src);
            end
         end
         default: begin
            // unknown kind: ignored
         end
      endcase
   endfunction

   // one request beat: random idle gap, then hold the payload until accepted;
   // valid stays high afterwards so a zero gap gives back-to-back beats
   task automatic send_request(logic [KIND_W-1:0] kind, logic [VERTEX_W-1:0] src,
                               logic [VERTEX_W-1:0] dest);
      int unsigned gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_src   <= src;
      req_dest  <= dest;
      do @(posedge clock); while (req_stall);
      predict_visits(kind, src, dest);
   endtask

   // drop valid, wait for every owed beat, then let a trailing add or clear finish
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_visits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_vertex_cap(logic [CFG_W-1:0] value);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      vertex_cap = value;
   endtask

   function automatic logic [VERTEX_W-1:0] pick_vertex(int pool);
      if ($urandom_range(9) == 0) begin
         return VERTEX_W'($urandom_range(MAX_VERTEX_COUNT - 1));
      end
      return VERTEX_W'($urandom_range(pool - 1));
   endfunction

   // consumer: one stall draw per accepted result beat, held for that many cycles
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // result check against the oldest owed beat, field by field
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         stall_left = draw_wait();
         if (expected_visits.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual vertex %0d status %0d last %0d",
                     $time, rsp_visited_vertex, rsp_status, rsp_last);
            mismatch_count++;
         end else begin
            oldest_visit = expected_visits.pop_front();
            if (rsp_visited_vertex !== oldest_visit.vertex) begin
               $display("%0t: visited_vertex mismatch, expected %0d, actual %0d",
                        $time, oldest_visit.vertex, rsp_visited_vertex);
               mismatch_count++;
            end
            if (rsp_status !== oldest_visit.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, oldest_visit.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_last !== oldest_visit.last) begin
               $display("%0t: last mismatch, expected %0d, actual %0d",
                        $time, oldest_visit.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // empty graph, vertex and destination extremes, already-visited start,
   // the ignored kind, and a clear between walks
   task automatic test_walk_extremes();
      send_request(KIND_TRAVERSE, 6'd0, 6'd63);
      send_request(KIND_ADD, 6'd0, 6'd63);
      send_request(KIND_ADD, 6'd63, 6'd0);
      send_request(KIND_ADD, 6'd0, 6'd1);
      send_request(KIND_ADD, 6'd1, 6'd63);
      send_request(KIND_TRAVERSE, 6'd0, 6'd0);
      send_request(KIND_TRAVERSE, 6'd63, 6'd0);
      send_request(KIND_UNUSED, 6'd63, 6'd63);
      send_request(KIND_CLEAR, 6'd63, 6'd63);
      send_request(KIND_TRAVERSE, 6'd63, 6'd0);
   endtask

   // limit of zero rejects everything, an oversized value saturates, limit of one
   // allows only a self loop
   task automatic test_limit_extremes();
      write_vertex_cap(CFG_W'(0));
      send_request(KIND_ADD, 6'd0, 6'd0);
      send_request(KIND_TRAVERSE, 6'd0, 6'd0);
      write_vertex_cap(CFG_W'(127));
      send_request(KIND_ADD, 6'd63, 6'd62);
      send_request(KIND_TRAVERSE, 6'd63, 6'd0);
      write_vertex_cap(CFG_W'(1));
      send_request(KIND_CLEAR, 6'd0, 6'd0);
      send_request(KIND_ADD, 6'd0, 6'd0);
      send_request(KIND_ADD, 6'd0, 6'd1);
      send_request(KIND_ADD, 6'd1, 6'd0);
      send_request(KIND_TRAVERSE, 6'd0, 6'd0);
      send_request(KIND_TRAVERSE, 6'd1, 6'd0);
   endtask

   // edges stored under a high limit are still followed after the limit drops;
   // clear leaves the register alone
   task automatic test_lowered_limit();
      write_vertex_cap(CFG_W'(64));
      send_request(KIND_CLEAR, 6'd0, 6'd0);
      send_request(KIND_ADD, 6'd0, 6'd5);
      send_request(KIND_ADD, 6'd0, 6'd10);
      send_request(KIND_ADD, 6'd10, 6'd20);
      send_request(KIND_ADD, 6'd20, 6'd30);
      write_vertex_cap(CFG_W'(4));
      send_request(KIND_TRAVERSE, 6'd0, 6'd0);
      send_request(KIND_TRAVERSE, 6'd5, 6'd0);
      send_request(KIND_CLEAR, 6'd0, 6'd0);
      send_request(KIND_TRAVERSE, 6'd5, 6'd0);
      send_request(KIND_TRAVERSE, 6'd3, 6'd0);
   endtask

   // fill the edge store, one more add is rejected, walks still work, clear frees it
   task automatic test_full_store();
      write_vertex_cap(CFG_W'(16));
      send_request(KIND_CLEAR, 6'd0, 6'd0);
      repeat (MAX_EDGE_COUNT) begin
         send_request(KIND_ADD, VERTEX_W'($urandom_range(15)), VERTEX_W'($urandom_range(15)));
      end
      send_request(KIND_ADD, 6'd3, 6'd4);
      send_request(KIND_TRAVERSE, 6'd0, 6'd0);
      send_request(KIND_TRAVERSE, VERTEX_W'($urandom_range(15)), 6'd0);
      send_request(KIND_CLEAR, 6'd0, 6'd0);
      send_request(KIND_ADD, 6'd3, 6'd4);
      send_request(KIND_TRAVERSE, 6'd3, 6'd0);
   endtask

   // random graphs: clear, a burst of adds over a small vertex pool with walks mixed in,
   // then a few walks; some out-of-range vertices and ignored kinds as noise
   task automatic test_random_graphs(logic [CFG_W-1:0] cap, int unsigned budget);
      int unsigned sent;
      int          lim;
      int          pool;
      int          arcs;
      write_vertex_cap(cap);
      sent = 0;
      while (sent < budget) begin
         steady = ($urandom_range(3) == 0);
         lim = vertex_limit();
         if (lim == 0) begin
            pool = 1;
         end else if ($urandom_range(3) == 0 || lim <= 12) begin
            pool = $urandom_range(lim, 1);
         end else begin
            pool = $urandom_range(12, 1);
         end
         send_request(KIND_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
         sent++;
         arcs = $urandom_range(2 * pool + 2);
         if (arcs > 24) begin
            arcs = 24;
         end
         repeat (arcs) begin
            send_request(KIND_ADD, pick_vertex(pool), pick_vertex(pool));
            sent++;
            if ($urandom_range(7) == 0) begin
               send_request(KIND_TRAVERSE, pick_vertex(pool), VERTEX_W'($urandom));
               sent++;
            end
            if ($urandom_range(19) == 0) begin
               send_request(KIND_UNUSED, VERTEX_W'($urandom), VERTEX_W'($urandom));
            end
         end
         repeat ($urandom_range(4, 1)) begin
            send_request(KIND_TRAVERSE, pick_vertex(pool), VERTEX_W'($urandom));
            sent++;
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      forget_graph();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_walk_extremes();
      test_limit_extremes();
      test_lowered_limit();
      test_full_store();
      test_random_graphs(CFG_W'(64), 10);
      test_random_graphs(CFG_W'(5), 6);
      test_random_graphs(CFG_W'($urandom_range(127)), 6);

      // drain, then wait quietly to catch stray beats
      settle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
